// ===== hw/rtl/oafa_pkg.sv =====
// ----------------------------------------------------------------------------
// oafa_pkg
// Shared types and constants of the obstacle and fall alert controller.
// ----------------------------------------------------------------------------
`default_nettype none

package oafa_pkg;

   localparam int DIST_W  = 13;
   localparam int RUN_W   = 8;
   localparam int MS16_W  = 16;
   localparam int TIME_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // block constants, distances in 0.1 cm, times in ms
   localparam logic [DIST_W-1:0] NO_OBSTACLE_DISTANCE = 13'd3000;
   localparam logic [MS16_W-1:0] FALL_VIBRATION_MS    = 16'd3000;
   localparam logic [TIME_W:0]   ALERT_HOLD_MS        = 33'd30000;
   localparam logic [DIST_W-1:0] ZONE_LOW             = 13'd500;
   localparam logic [DIST_W-1:0] ZONE_HIGH            = 13'd800;
   localparam logic [RUN_W-1:0]  RUN_MAX              = 8'd255;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_US_VALID_MAX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_THR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_THR      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_PULSE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_QUICK_PULSE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_GAP    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE        = 3'd7;

   typedef struct packed {
      logic [DIST_W-1:0]  us_valid_max;
      logic [DIST_W-1:0]  close_thr;
      logic [DIST_W-1:0]  far_thr;
      logic [RUN_W-1:0]   debounce;
      logic [MS16_W-1:0]  single_pulse;
      logic [MS16_W-1:0]  quick_pulse;
      logic [MS16_W:0]    quick_gap;       // quick + gap
      logic [MS16_W+1:0]  quick2_gap;      // 2*quick + gap
      logic [TIME_W-1:0]  grace;
      logic [TIME_W:0]    grace_hold;      // grace + hold, no wrap
   } cfg_type;

   // classified update passed from front to back
   typedef struct packed {
      logic [DIST_W-1:0] fused;
      logic              raw_close;
      logic              raw_far;
      logic              fall;
      logic [TIME_W-1:0] now;
   } entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/oafa_front.sv =====
// ----------------------------------------------------------------------------
// oafa_front
// Distance fusion by zone rules and raw close / far classification.
// ----------------------------------------------------------------------------
`default_nettype none

module oafa_front (
   input  wire  oafa_pkg::cfg_type   cfg,
   input  wire  [63:0]               item_data,
   output oafa_pkg::entry_type       entry
);

   logic                          ir_ok;
   logic [oafa_pkg::DIST_W-1:0]   ir;
   logic                          us_ok;
   logic [oafa_pkg::DIST_W-1:0]   us;
   logic [oafa_pkg::DIST_W-1:0]   both_min;
   logic [oafa_pkg::DIST_W-1:0]   fused;

   assign ir_ok = item_data[0];
   assign ir    = item_data[13:1];
   assign us    = item_data[27:15];
   assign us_ok = item_data[14] && (us <= cfg.us_valid_max);
   assign both_min = (ir < us) ? ir : us;

   always_comb begin
      if (ir_ok && us_ok && ir >= oafa_pkg::ZONE_LOW && us <= oafa_pkg::ZONE_HIGH) begin
         fused = both_min;
      end else if (ir_ok && ir < oafa_pkg::ZONE_LOW) begin
         fused = ir;
      end else if (us_ok && us > oafa_pkg::ZONE_HIGH) begin
         fused = us;
      end else if (ir_ok && us_ok) begin
         fused = both_min;
      end else if (ir_ok) begin
         fused = ir;
      end else if (us_ok) begin
         fused = us;
      end else begin
         fused = oafa_pkg::NO_OBSTACLE_DISTANCE;
      end
   end

   always_comb begin
      entry.fused     = fused;
      entry.raw_close = (fused <= cfg.close_thr);
      entry.raw_far   = (fused > cfg.close_thr) && (fused <= cfg.far_thr);
      entry.fall      = item_data[28];
      entry.now       = item_data[60:29];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/oafa_queue.sv =====
// ----------------------------------------------------------------------------
// oafa_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module oafa_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  wr_en,
   input  wire  oafa_pkg::entry_type wr_data,
   output logic                 full,
   output logic                 not_empty,
   input  wire                  rd_en,
   output oafa_pkg::entry_type  rd_data
);

   oafa_pkg::entry_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign rd_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 2'd1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/oafa_back.sv =====
// ----------------------------------------------------------------------------
// oafa_back
// Debounce, fall machine, vibration pattern timing and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oafa_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  oafa_pkg::cfg_type cfg,
   input  wire                  q_valid,
   input  wire  oafa_pkg::entry_type q_data,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [23:0]          rsp_tdata
);

   typedef enum logic [1:0] {
      FALL_IDLE, FALL_TRIGGERED, FALL_GRACE, FALL_SENT
   } fall_type;

   localparam logic [1:0] LEVEL_NONE  = 2'd0;
   localparam logic [1:0] LEVEL_FAR   = 2'd1;
   localparam logic [1:0] LEVEL_CLOSE = 2'd2;

   localparam logic [1:0] PAT_OFF    = 2'd0;
   localparam logic [1:0] PAT_SHORT  = 2'd1;
   localparam logic [1:0] PAT_DOUBLE = 2'd2;
   localparam logic [1:0] PAT_CONT   = 2'd3;

   fall_type                        fall_ff, fall_in;
   logic [1:0]                      level_ff, level_in;
   logic [oafa_pkg::RUN_W-1:0]      close_run_ff, close_run_in;
   logic [oafa_pkg::RUN_W-1:0]      far_run_ff, far_run_in;
   logic [oafa_pkg::TIME_W-1:0]     fall_stamp_ff, fall_stamp_in;
   logic [1:0]                      pat_ff, pat_in;
   logic [oafa_pkg::TIME_W-1:0]     pat_stamp_ff, pat_stamp_in;
   logic                            valid_ff;
   logic [23:0]                     data_ff, data_in;

   logic [oafa_pkg::TIME_W-1:0]     since;
   logic [oafa_pkg::TIME_W-1:0]     elapsed;
   logic                            alert;
   logic                            motor;

   assign q_pop      = q_valid && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign since      = q_data.now - fall_stamp_ff;

   always_comb begin
      close_run_in  = close_run_ff;
      far_run_in    = far_run_ff;
      level_in      = level_ff;
      fall_in       = fall_ff;
      fall_stamp_in = fall_stamp_ff;
      pat_stamp_in  = pat_stamp_ff;
      alert         = 1'b0;
      motor         = 1'b0;

      // debounce: promote after a run, drop to none at once
      if (q_data.raw_close) begin
         if (close_run_ff != oafa_pkg::RUN_MAX) begin
            close_run_in = close_run_ff + 8'd1;
         end
         far_run_in = '0;
         if (close_run_in >= cfg.debounce) begin
            level_in = LEVEL_CLOSE;
         end
      end else if (q_data.raw_far) begin
         if (far_run_ff != oafa_pkg::RUN_MAX) begin
            far_run_in = far_run_ff + 8'd1;
         end
         close_run_in = '0;
         if (far_run_in >= cfg.debounce) begin
            level_in = LEVEL_FAR;
         end
      end else begin
         close_run_in = '0;
         far_run_in   = '0;
         level_in     = LEVEL_NONE;
      end

      unique case (fall_ff)
         FALL_IDLE: begin
            if (q_data.fall) begin
               fall_stamp_in = q_data.now;
               fall_in       = FALL_TRIGGERED;
            end
         end
         FALL_TRIGGERED: begin
            fall_in = FALL_GRACE;
         end
         FALL_GRACE: begin
            if (since >= cfg.grace) begin
               fall_in = FALL_SENT;
               alert   = 1'b1;
            end
         end
         FALL_SENT: begin
            if ({1'b0, since} >= cfg.grace_hold) begin
               fall_in = FALL_IDLE;
            end
         end
         default: begin
            fall_in = FALL_IDLE;
         end
      endcase

      if (fall_in == FALL_TRIGGERED || fall_in == FALL_GRACE) begin
         pat_in = PAT_CONT;
      end else if (level_in == LEVEL_CLOSE) begin
         pat_in = PAT_DOUBLE;
      end else if (level_in == LEVEL_FAR) begin
         pat_in = PAT_SHORT;
      end else begin
         pat_in = PAT_OFF;
      end

      // a new pattern restarts its timer
      if (pat_in != pat_ff) begin
         pat_stamp_in = q_data.now;
         elapsed      = '0;
      end else begin
         elapsed      = q_data.now - pat_stamp_ff;
      end

      case (pat_in)
         PAT_SHORT:  motor = (elapsed < {16'd0, cfg.single_pulse});
         PAT_DOUBLE: begin
            if (elapsed < {16'd0, cfg.quick_pulse}) begin
               motor = 1'b1;
            end else if (elapsed < {15'd0, cfg.quick_gap}) begin
               motor = 1'b0;
            end else begin
               motor = (elapsed < {14'd0, cfg.quick2_gap});
            end
         end
         PAT_CONT:   motor = (elapsed < {16'd0, oafa_pkg::FALL_VIBRATION_MS});
         default:    motor = 1'b0;
      endcase

      data_in = {3'd0, alert, motor, pat_in, fall_in, level_in, q_data.fused};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fall_ff       <= FALL_IDLE;
         level_ff      <= LEVEL_NONE;
         close_run_ff  <= '0;
         far_run_ff    <= '0;
         fall_stamp_ff <= '0;
         pat_ff        <= PAT_OFF;
         pat_stamp_ff  <= '0;
         valid_ff      <= 1'b0;
      end else begin
         if (q_pop) begin
            fall_ff       <= fall_in;
            level_ff      <= level_in;
            close_run_ff  <= close_run_in;
            far_run_ff    <= far_run_in;
            fall_stamp_ff <= fall_stamp_in;
            pat_ff        <= pat_in;
            pat_stamp_ff  <= pat_stamp_in;
            valid_ff      <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff      <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/obstacle_and_fall_alert_controller.sv =====
// ----------------------------------------------------------------------------
// obstacle_and_fall_alert_controller
// Fuses IR / ultrasonic distances, debounces obstacle level, runs the fall
// alert machine and times the vibration motor.
//
// Usage:
//   req_* carries one sensor update per transaction; rsp_* returns exactly
//   one result per update, in order. csr_* writes the eight registers by
//   index; the user writes them only while no update is in flight, which
//   the block does not enforce. The front fuses and classifies an update as
//   it is accepted and pushes it into a two-entry queue; the back pops it,
//   updates debounce, fall and pattern state and loads the result register.
//   An update passes through a queue entry and then the result register
//   before rsp_tvalid rises. Throughput: one update per cycle while rsp_tready
//   is high, set by the state update in the back.
//   When rsp_tready is low the result register holds; the queue keeps
//   taking updates until both entries are filled, then req_tready drops.
//   Synchronous reset clears control state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_and_fall_alert_controller (
   input  wire          clock,
   input  wire          reset,
   // ir_valid, ir_distance[12:0], ultrasonic_valid, ultrasonic_distance[12:0],
   // fall_seen, now_ms[31:0], zero pad
   input  wire  [63:0]  req_tdata,
   input  wire          req_tvalid,
   output logic         req_tready,
   // fused_distance[12:0], obstacle_level[1:0], fall_phase[1:0],
   // vibration_pattern[1:0], motor_drive, send_alert, zero pad
   output logic [23:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   input  wire          csr_we,
   input  wire  [oafa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [oafa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   oafa_pkg::cfg_type   cfg_ff, cfg_in;
   oafa_pkg::entry_type front_entry;
   oafa_pkg::entry_type q_data;
   logic                q_full;
   logic                q_valid;
   logic                q_pop;
   logic                push;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   // derived sums are formed at write time
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            oafa_pkg::CSR_US_VALID_MAX: cfg_in.us_valid_max = csr_wdata[12:0];
            oafa_pkg::CSR_CLOSE_THR:    cfg_in.close_thr    = csr_wdata[12:0];
            oafa_pkg::CSR_FAR_THR:      cfg_in.far_thr      = csr_wdata[12:0];
            oafa_pkg::CSR_DEBOUNCE:     cfg_in.debounce     = csr_wdata[7:0];
            oafa_pkg::CSR_SINGLE_PULSE: cfg_in.single_pulse = csr_wdata[15:0];
            oafa_pkg::CSR_QUICK_PULSE: begin
               cfg_in.quick_pulse = csr_wdata[15:0];
               cfg_in.quick_gap   = {1'b0, csr_wdata[15:0]} +
                                    (cfg_ff.quick_gap - {1'b0, cfg_ff.quick_pulse});
               cfg_in.quick2_gap  = {1'b0, csr_wdata[15:0], 1'b0} +
                                    ({1'b0, cfg_ff.quick_gap} -
                                     {2'b0, cfg_ff.quick_pulse});
            end
            oafa_pkg::CSR_PULSE_GAP: begin
               cfg_in.quick_gap  = {1'b0, cfg_ff.quick_pulse} + {1'b0, csr_wdata[15:0]};
               cfg_in.quick2_gap = {1'b0, cfg_ff.quick_pulse, 1'b0} +
                                   {2'b0, csr_wdata[15:0]};
            end
            oafa_pkg::CSR_GRACE: begin
               cfg_in.grace      = csr_wdata;
               cfg_in.grace_hold = {1'b0, csr_wdata} + oafa_pkg::ALERT_HOLD_MS;
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.us_valid_max <= 13'd3000;
         cfg_ff.close_thr    <= 13'd500;
         cfg_ff.far_thr      <= 13'd1500;
         cfg_ff.debounce     <= 8'd3;
         cfg_ff.single_pulse <= 16'd200;
         cfg_ff.quick_pulse  <= 16'd100;
         cfg_ff.quick_gap    <= 17'd200;
         cfg_ff.quick2_gap   <= 18'd300;
         cfg_ff.grace        <= 32'd10000;
         cfg_ff.grace_hold   <= 33'd10000 + oafa_pkg::ALERT_HOLD_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   oafa_front u_front (
      .cfg       (cfg_ff),
      .item_data (req_tdata),
      .entry     (front_entry)
   );

   oafa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (push),
      .wr_data   (front_entry),
      .full      (q_full),
      .not_empty (q_valid),
      .rd_en     (q_pop),
      .rd_data   (q_data)
   );

   oafa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
